// ===== hdl/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg: shared types and constants for the Modbus RTU response checker
// Holds the word layouts, register indexes, status codes and the CRC-16
// byte update.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    // Input word: one received byte or a timeout marker
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_timeout;
    } mrrc_in_t;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic [7:0] frame_length;
    } mrrc_out_t;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  expected_slave;
        logic [6:0]  expected_function;
        logic [7:0]  expected_length;
        logic [1:0]  check_mode;
        logic [15:0] echo_word_a;
        logic [15:0] echo_word_b;
    } mrrc_cfg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXP_SLAVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_FUNC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_A     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_B     = 3'd5;

    // Check modes
    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_BYTECOUNT = 2'd1;
    localparam logic [1:0] MODE_ECHO      = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CRC       = 3'd1;
    localparam logic [2:0] ST_SLAVE     = 3'd2;
    localparam logic [2:0] ST_EXCEPTION = 3'd3;
    localparam logic [2:0] ST_FUNCTION  = 3'd4;
    localparam logic [2:0] ST_SHORT     = 3'd5;
    localparam logic [2:0] ST_BYTECOUNT = 3'd6;
    localparam logic [2:0] ST_ECHO      = 3'd7;

    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  MIN_FRAME = 8'd5;

    // Reset values of the registers
    localparam logic [7:0] RST_EXP_SLAVE  = 8'd1;
    localparam logic [6:0] RST_EXP_FUNC   = 7'd3;
    localparam logic [7:0] RST_EXP_LENGTH = 8'd8;

    // One byte through the reflected CRC-16, LSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] c_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mrrc_in_stage.sv =====
// ----------------------------------------------------------------------------
// mrrc_in_stage: input register
// Captures one input word and holds it until the checker takes it.
// ----------------------------------------------------------------------------
module mrrc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrrc_pkg::mrrc_in_t s_data,
    input  logic              take,
    output logic              q_valid,
    output mrrc_pkg::mrrc_in_t q_data
);
    import mrrc_pkg::*;

    logic     valid_reg, valid_next;
    mrrc_in_t data_reg;

    // Free when empty or when the held word leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ===== hdl/mrrc_frame_check.sv =====
// ----------------------------------------------------------------------------
// mrrc_frame_check: frame state and per-byte checking
// Keeps the running CRC, byte count and captured header bytes, and builds
// the result word for each byte or timeout.
// ----------------------------------------------------------------------------
module mrrc_frame_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  mrrc_pkg::mrrc_in_t  in_data,
    input  mrrc_pkg::mrrc_cfg_t cfg,
    output logic                res_valid,
    output mrrc_pkg::mrrc_out_t res_data
);
    import mrrc_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  slave_reg, slave_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  third_reg, third_next;
    logic        echo_bad_reg, echo_bad_next;

    logic [15:0] crc_upd;
    logic [8:0]  len;
    logic [7:0]  eff_len;
    logic [7:0]  echo_exp;
    logic        echo_slot;
    logic        is_exc;
    logic        closing;
    logic [2:0]  st;
    logic        in_frame;

    // Per-byte datapath
    always_comb begin
        crc_upd   = crc16_feed(crc_reg, in_data.rx_byte);
        len       = {1'b0, count_reg} + 9'd1;
        eff_len   = (cfg.expected_length < MIN_FRAME) ? MIN_FRAME : cfg.expected_length;
        echo_slot = (count_reg >= 8'd2) && (count_reg <= 8'd5);
        unique case (count_reg[1:0])
            2'd2:    echo_exp = cfg.echo_word_a[15:8];
            2'd3:    echo_exp = cfg.echo_word_a[7:0];
            2'd0:    echo_exp = cfg.echo_word_b[15:8];
            default: echo_exp = cfg.echo_word_b[7:0];
        endcase
        slave_next    = (count_reg == 8'd0) ? in_data.rx_byte : slave_reg;
        func_next     = (count_reg == 8'd1) ? in_data.rx_byte : func_reg;
        third_next    = (count_reg == 8'd2) ? in_data.rx_byte : third_reg;
        echo_bad_next = echo_bad_reg || (echo_slot && (in_data.rx_byte != echo_exp));
        is_exc  = (len >= 9'd2) && (func_next == {1'b1, cfg.expected_function});
        closing = (is_exc && (len >= {1'b0, MIN_FRAME})) || (len >= {1'b0, eff_len});
        in_frame = (count_reg != 8'd0);
    end

    // Closing status, in priority order
    always_comb begin
        priority if (crc_upd != 16'h0000) begin
            st = ST_CRC;
        end else if (slave_next != cfg.expected_slave) begin
            st = ST_SLAVE;
        end else if (is_exc) begin
            st = ST_EXCEPTION;
        end else if (func_next != {1'b0, cfg.expected_function}) begin
            st = ST_FUNCTION;
        end else if ((cfg.check_mode == MODE_BYTECOUNT)
                     && (third_next != (eff_len - MIN_FRAME))) begin
            st = ST_BYTECOUNT;
        end else if ((cfg.check_mode == MODE_ECHO) && echo_bad_next) begin
            st = ST_ECHO;
        end else begin
            st = ST_OK;
        end
    end

    // Result word and next state
    always_comb begin
        crc_next = crc_reg;
        count_next = count_reg;
        res_valid = 1'b0;
        res_data = '0;
        if (in_data.rx_timeout) begin
            // timeout closes a frame in progress as short
            res_valid = in_frame;
            res_data.done_res = 1'b1;
            res_data.status = ST_SHORT;
            res_data.frame_length = count_reg;
            crc_next = CRC_SEED;
            count_next = 8'd0;
        end else begin
            res_valid = 1'b1;
            res_data.out_byte = in_data.rx_byte;
            res_data.byte_index = count_reg;
            if (closing) begin
                res_data.done_res = 1'b1;
                res_data.status = st;
                res_data.exception_code = (st == ST_EXCEPTION) ? third_next : 8'd0;
                res_data.frame_length = len[7:0];
                crc_next = CRC_SEED;
                count_next = 8'd0;
            end else begin
                crc_next = crc_upd;
                count_next = len[7:0];
            end
        end
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_SEED;
            count_reg    <= 8'd0;
            slave_reg    <= 8'd0;
            func_reg     <= 8'd0;
            third_reg    <= 8'd0;
            echo_bad_reg <= 1'b0;
        end else if (step) begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            if (count_next == 8'd0) begin
                slave_reg    <= 8'd0;
                func_reg     <= 8'd0;
                third_reg    <= 8'd0;
                echo_bad_reg <= 1'b0;
            end else begin
                slave_reg    <= slave_next;
                func_reg     <= func_next;
                third_reg    <= third_next;
                echo_bad_reg <= echo_bad_next;
            end
        end
    end

endmodule

// ===== hdl/modbus_rtu_response_checker_core.sv =====
// ----------------------------------------------------------------------------
// Path: an accepted word goes via the input register to the result register.
// Throughput: one word per cycle while m_ready is high; the CRC byte update
//   is an unrolled eight-step shift between the input and result registers.
// Reset (aresetn low, synchronous): both pipeline registers empty, frame
//   state cleared (CRC seed 0xFFFF), registers back to their defaults.
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core: top level
// Checks Modbus RTU responses byte by byte: CRC, slave, function, exception
// and body checks, echoing each byte with its index.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  mrrc_pkg::mrrc_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output mrrc_pkg::mrrc_out_t                  m_data,
    input  logic                                 cfg_wr_en,
    input  logic [mrrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import mrrc_pkg::*;

    mrrc_cfg_t  cfg_reg;
    logic       q_valid;
    mrrc_in_t   q_data;
    logic       take;
    logic       res_valid;
    mrrc_out_t  res_data;
    logic       m_valid_reg, m_valid_next;
    mrrc_out_t  m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_slave    <= RST_EXP_SLAVE;
            cfg_reg.expected_function <= RST_EXP_FUNC;
            cfg_reg.expected_length   <= RST_EXP_LENGTH;
            cfg_reg.check_mode        <= MODE_NONE;
            cfg_reg.echo_word_a       <= 16'd0;
            cfg_reg.echo_word_b       <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EXP_SLAVE:  cfg_reg.expected_slave    <= cfg_wr_data[7:0];
                REG_EXP_FUNC:   cfg_reg.expected_function <= cfg_wr_data[6:0];
                REG_EXP_LENGTH: cfg_reg.expected_length   <= cfg_wr_data[7:0];
                REG_CHECK_MODE: cfg_reg.check_mode        <= cfg_wr_data[1:0];
                REG_ECHO_A:     cfg_reg.echo_word_a       <= cfg_wr_data;
                REG_ECHO_B:     cfg_reg.echo_word_b       <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Held word moves on when the result register has room
    assign take = q_valid && (!m_valid_reg || m_ready);

    mrrc_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (take),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    mrrc_frame_check u_frame_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .in_data   (q_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result register
    always_comb begin
        if (take && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
